[rtl/core/lcfc_pkg.sv]
// Shared types and constants for the load-cell force conditioner.
// Holds field widths, command codes, state codes and the divider request.
// No dependencies.
package lcfc_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int FILT_W        = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam int ALPHA_W       = 17;
  localparam int CPK_W         = 24;
  localparam int FORCE_W       = 24;
  localparam int TARED_W       = SAMPLE_BITS + 1;
  // Magnitude of tared counts times 1000 fits in TARED_W + 9 bits.
  localparam int NUM_W         = TARED_W + 9;
  localparam int PROD_W        = NUM_W + 1;
  localparam int MCNT_W        = $clog2(ALPHA_W);
  localparam int DCNT_W        = $clog2(NUM_W);
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = CPK_W;

  // Alpha of one in Q1.16, and the reset values of the registers.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);
  localparam logic [CPK_W-1:0]   CPK_RESET   = CPK_W'(20000);

  // Force saturation limits and their magnitudes.
  localparam logic [FORCE_W-1:0] FORCE_MAX     = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] FORCE_MIN     = {1'b1, {(FORCE_W-1){1'b0}}};
  localparam logic [NUM_W-1:0]   FORCE_MAX_MAG = NUM_W'((64'd1 << (FORCE_W-1)) - 64'd1);
  localparam logic [NUM_W-1:0]   FORCE_MIN_MAG = NUM_W'(64'd1 << (FORCE_W-1));

  // Command codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_TARE     = 2'd1,
    OP_PEAK_CLR = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 1'b0,
    CFG_CPK   = 1'b1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_DIV,
    ST_OUT
  } state_t;

  // Request from the sequencer to the serial divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CPK_W-1:0] den;
  } div_req_t;

endpackage

[rtl/core/lcfc_div.sv]
// Bit-serial restoring divider for the force calculation, one quotient bit per cycle.
// Depends on lcfc_pkg for widths and the request struct.
module lcfc_div import lcfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [CPK_W-1:0]  rem;
  logic [CPK_W-1:0]  den;
  logic [NUM_W-1:0]  qr;
  logic [CPK_W:0]    shifted;
  logic [CPK_W+1:0]  trial;
  logic              fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem, qr[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};
  assign fits    = ~trial[CPK_W+1];
  assign quot    = qr;

  // Control: run for NUM_W steps after a start, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DCNT_W'(NUM_W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      den <= req.den;
      qr  <= req.num;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= fits ? trial[CPK_W-1:0] : shifted[CPK_W-1:0];
      qr  <= {qr[NUM_W-2:0], fits};
    end
  end

  // The partial remainder always stays below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den)
    else $error("divider remainder reached the divisor");

  // A new division never starts on top of a running one.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");

  // Done follows the last step of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

endmodule

[rtl/core/load_cell_force_conditioner.sv]
// Top level of the load-cell force conditioner: EMA filter, tare, scaling and peak hold.
// Sequence: a primed sample runs a 17-step shift-add multiply, the divider start, a 34-step
// serial divide and the hand-off to the output register; the priming sample skips the
// multiply; tare and peak-reset commands go straight to the hand-off, which waits while the
// output holds an unaccepted result. Flow: a new word is taken only once the last one is
// handed off, so a new word is taken while the last result waits.
// Reset (synchronous): clears filter, tare offset, peak and force; registers to defaults.
module load_cell_force_conditioner import lcfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // [23:0] raw_sample
  input  logic [1:0]            s_axis_tuser,   // [1:0] op
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [79:0]           m_axis_tdata,   // [23:0] force_grams, [47:24] peak_grams,
                                                // [72:48] tared_counts, [79:73] zero
  output logic [1:0]            m_axis_tuser    // [0] primed, [1] rejected
);

  state_t               state, state_next;
  op_t                  op_q, op_q_next;
  logic                 rejected, rejected_next;
  logic                 primed, primed_next;
  logic [FILT_W-1:0]    filt, filt_next;
  logic [SAMPLE_BITS-1:0] tare_off, tare_off_next;
  logic [FORCE_W-1:0]   peak, peak_next;
  logic [FORCE_W-1:0]   cur_force, cur_force_next;
  logic [FILT_W-1:0]    diff, diff_next;
  logic [FILT_W:0]      acc, acc_next;
  logic [ALPHA_W-1:0]   ash, ash_next;
  logic [MCNT_W-1:0]    mcnt, mcnt_next;
  logic                 load_out;

  logic [ALPHA_W-1:0]   alpha;
  logic [CPK_W-1:0]     cpk;

  logic [FORCE_W-1:0]   out_force;
  logic [FORCE_W-1:0]   out_peak;
  logic [TARED_W-1:0]   out_tared;
  logic                 out_primed;
  logic                 out_rejected;
  logic                 m_valid;

  logic [SAMPLE_BITS-1:0] in_raw;
  logic [FILT_W-1:0]    target;
  logic [ALPHA_W-1:0]   alpha_eff;
  logic [FILT_W:0]      mul_add;
  logic [FILT_W:0]      mul_sum;
  logic [SAMPLE_BITS-1:0] int_part;
  logic [TARED_W-1:0]   tared_full;
  logic [TARED_W-1:0]   tared_now;
  logic [TARED_W-1:0]   tared_mag;
  logic [PROD_W-1:0]    prod;
  logic [FORCE_W-1:0]   sat_force;
  logic                 div_start;
  div_req_t             div_req;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;

  // Configuration registers; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
      cpk   <= CPK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA: alpha <= cfg_data[ALPHA_W-1:0];
        CFG_CPK:   cpk   <= cfg_data[CPK_W-1:0];
        default:   ;
      endcase
    end
  end

  // Sample as Q24.16 target, and the clamped filter weight.
  assign in_raw    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign target    = {in_raw[SAMPLE_BITS-1], in_raw, {FRACTION_BITS{1'b0}}};
  assign alpha_eff = alpha[ALPHA_W-1] ? ALPHA_ONE : alpha;

  // One step of the shift-add multiply: add the difference when the alpha bit is set.
  assign mul_add = ash[0] ? {diff[FILT_W-1], diff} : '0;
  assign mul_sum = acc + mul_add;

  // Floor of the filter value minus the tare offset.
  assign int_part   = filt[FILT_W-2 -: SAMPLE_BITS];
  assign tared_full = {int_part[SAMPLE_BITS-1], int_part} - {tare_off[SAMPLE_BITS-1], tare_off};
  assign tared_now  = primed ? tared_full : '0;

  // Magnitude times 1000 as 1024 - 16 - 8.
  assign tared_mag = tared_now[TARED_W-1] ? (~tared_now + 1'b1) : tared_now;
  assign prod      = {tared_mag, 10'b0} - {6'b0, tared_mag, 4'b0} - {7'b0, tared_mag, 3'b0};

  // Divider request; a zero factor counts as one.
  assign div_req = {div_start, prod[NUM_W-1:0], ((cpk == '0) ? CPK_W'(1) : cpk)};

  lcfc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // Restore the sign and saturate the quotient to the force range.
  always_comb begin
    if (!tared_now[TARED_W-1]) begin
      sat_force = (div_quot > FORCE_MAX_MAG) ? FORCE_MAX : div_quot[FORCE_W-1:0];
    end else begin
      sat_force = (div_quot > FORCE_MIN_MAG) ? FORCE_MIN :
                  FORCE_W'(~div_quot[FORCE_W-1:0] + 1'b1);
    end
  end

  // State register and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      filt      <= '0;
      tare_off  <= '0;
      peak      <= '0;
      cur_force <= '0;
      rejected  <= 1'b0;
    end else begin
      state     <= state_next;
      primed    <= primed_next;
      filt      <= filt_next;
      tare_off  <= tare_off_next;
      peak      <= peak_next;
      cur_force <= cur_force_next;
      rejected  <= rejected_next;
    end
  end

  // Multiply working registers and the latched command.
  always_ff @(posedge clk) begin
    op_q <= op_q_next;
    diff <= diff_next;
    acc  <= acc_next;
    ash  <= ash_next;
    mcnt <= mcnt_next;
  end

  // Next state and datapath control.
  always_comb begin
    state_next     = state;
    op_q_next      = op_q;
    rejected_next  = rejected;
    primed_next    = primed;
    filt_next      = filt;
    tare_off_next  = tare_off;
    peak_next      = peak;
    cur_force_next = cur_force;
    diff_next      = diff;
    acc_next       = acc;
    ash_next       = ash;
    mcnt_next      = mcnt;
    div_start      = 1'b0;
    load_out       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_q_next     = op_t'(s_axis_tuser);
          rejected_next = 1'b0;
          state_next    = ST_OUT;
          unique case (op_t'(s_axis_tuser))
            OP_SAMPLE: begin
              if (!primed) begin
                filt_next   = target;
                primed_next = 1'b1;
                state_next  = ST_NORM;
              end else begin
                diff_next  = target - filt;
                acc_next   = '0;
                ash_next   = alpha_eff;
                mcnt_next  = '0;
                state_next = ST_MUL;
              end
            end
            OP_TARE: begin
              if (!primed) begin
                rejected_next = 1'b1;
              end else begin
                tare_off_next = int_part;
                peak_next     = '0;
              end
            end
            OP_PEAK_CLR: begin
              peak_next = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        // Low alpha bits shift the sum right; the top bit adds unshifted.
        ash_next  = ash >> 1;
        mcnt_next = mcnt + 1'b1;
        if (mcnt == MCNT_W'(ALPHA_W-1)) begin
          filt_next  = filt + mul_sum[FILT_W-1:0];
          state_next = ST_NORM;
        end else begin
          acc_next = {mul_sum[FILT_W], mul_sum[FILT_W:1]};
        end
      end
      ST_NORM: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          cur_force_next = sat_force;
          if ($signed(sat_force) > $signed(peak)) begin
            peak_next = sat_force;
          end
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_out) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_force    <= cur_force;
      out_peak     <= peak;
      out_tared    <= tared_now;
      out_primed   <= primed;
      out_rejected <= rejected;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'b0, out_tared, out_peak, out_force};
  assign m_axis_tuser  = {out_rejected, out_primed};

  // Once primed, the filter stays primed until reset.
  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("filter lost its primed state");

  // The divider only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  // After a sample the peak is never below the current force.
  a_peak_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && op_q == OP_SAMPLE) |-> $signed(peak) >= $signed(cur_force))
    else $error("peak below current force after a sample");

endmodule
